>>> rtl/rqa_pkg.sv
// shared constants, codes and types for the resource quota accountant
package rqa_pkg;

    localparam int NUM_TYPES_DEF = 3;
    localparam int MAX_TYPES     = 3;
    localparam int CNT_W         = 31;
    localparam int AMT_W         = 32;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_DEBIT  = 2'd0,
        ACT_CREDIT = 2'd1,
        ACT_ADJUST = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_LIMIT        = 3'd1,
        ST_BAD_TYPE     = 3'd2,
        ST_NEG_AMOUNT   = 3'd3,
        ST_UNDERFLOW    = 3'd4,
        ST_REF_NEGATIVE = 3'd5,
        ST_RELEASE_BUSY = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMIT_ZERO = 2'd0,
        REG_LIMIT_ONE  = 2'd1,
        REG_LIMIT_TWO  = 2'd2,
        REG_BYPASS     = 2'd3
    } cfg_reg_t;

endpackage

>>> rtl/resource_quota_accountant_unit.sv
// top level: usage and reference count accounting with per-type limits
// each item passes through an input register and then a result register
// throughput: one item per cycle unless out_ready stalls; the single-pass update of the usage
// registers and the reference count sets this, each item sees the state left by the one before
// reset: usage counters clear to zero, reference count to one, limits and bypass to zero
// reset is asynchronous and active low; no clearing pass is needed
module resource_quota_accountant_unit #(
    parameter int NUM_TYPES = rqa_pkg::NUM_TYPES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rqa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rqa_pkg::CNT_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    action,
    input  logic [1:0]                    resource_type,
    input  logic signed [rqa_pkg::AMT_W-1:0] amount,
    input  logic signed [rqa_pkg::AMT_W-1:0] refcount_delta,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          granted,
    output logic [2:0]                    status,
    output logic [rqa_pkg::CNT_W-1:0]     refcount_now,
    output logic                          released
);

    localparam int CW = rqa_pkg::CNT_W;
    localparam int AW = rqa_pkg::AMT_W;

    // input stage
    logic                 in_valid_reg;
    logic [1:0]           action_reg;
    logic [1:0]           type_reg;
    logic [AW-1:0]        amount_reg;
    logic [AW-1:0]        delta_reg;

    // result stage
    logic                 out_valid_reg;
    logic                 granted_reg;
    rqa_pkg::status_t     status_reg;
    logic [CW-1:0]        refcount_now_reg;
    logic                 released_reg;

    // accounting state and configuration
    logic [CW-1:0]        usage_reg [NUM_TYPES];
    logic [CW-1:0]        refcount_reg;
    logic [CW-1:0]        limit_reg [rqa_pkg::MAX_TYPES];
    logic                 bypass_reg;

    logic                 advance;
    logic                 fire;

    logic                 granted_next;
    rqa_pkg::status_t     status_next;
    logic                 released_next;
    logic [CW-1:0]        refcount_next;
    logic                 usage_we;
    logic [CW-1:0]        usage_next;

    logic                 type_ok;
    logic [CW-1:0]        use_sel;
    logic [CW-1:0]        lim_sel;
    logic                 others_nz;
    logic                 any_nz;
    logic [CW:0]          debit_sum;
    logic [CW-1:0]        credit_diff;
    logic [CW+1:0]        rc_sum;
    logic                 rc_neg;
    logic                 rc_zero;
    logic [CW-1:0]        rc_sat;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    assign out_valid    = out_valid_reg;
    assign granted      = granted_reg;
    assign status       = status_reg;
    assign refcount_now = refcount_now_reg;
    assign released     = released_reg;

    // operand selection
    always_comb
    begin
        type_ok   = (int'(type_reg) < NUM_TYPES);
        use_sel   = '0;
        lim_sel   = '0;
        others_nz = 1'b0;
        any_nz    = 1'b0;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            if (type_reg == 2'(i))
            begin
                use_sel = usage_reg[i];
            end
            else if (usage_reg[i] != '0)
            begin
                others_nz = 1'b1;
            end
            if (usage_reg[i] != '0)
            begin
                any_nz = 1'b1;
            end
        end
        for (int i = 0; i < rqa_pkg::MAX_TYPES; i++)
        begin
            if (type_reg == 2'(i))
            begin
                lim_sel = limit_reg[i];
            end
        end
    end

    assign debit_sum   = {1'b0, use_sel} + {1'b0, amount_reg[CW-1:0]};
    assign credit_diff = use_sel - amount_reg[CW-1:0];
    assign rc_sum      = {2'b00, refcount_reg} + {{2{delta_reg[AW-1]}}, delta_reg[CW-1:0]};
    assign rc_neg      = rc_sum[CW+1];
    assign rc_zero     = (rc_sum == '0);
    assign rc_sat      = (rc_sum[CW+1:CW] != 2'b00) ? rqa_pkg::CNT_MAX : rc_sum[CW-1:0];

    // request evaluation
    always_comb
    begin
        granted_next  = 1'b0;
        status_next   = rqa_pkg::ST_OK;
        released_next = 1'b0;
        refcount_next = refcount_reg;
        usage_we      = 1'b0;
        usage_next    = use_sel;
        unique case (action_reg)
            rqa_pkg::ACT_ADJUST:
            begin
                priority if (bypass_reg)
                begin
                    granted_next = 1'b1;
                end
                else if (rc_neg)
                begin
                    status_next = rqa_pkg::ST_REF_NEGATIVE;
                end
                else if (rc_zero && any_nz)
                begin
                    status_next = rqa_pkg::ST_RELEASE_BUSY;
                end
                else
                begin
                    granted_next  = 1'b1;
                    refcount_next = rc_sat;
                    released_next = rc_zero;
                end
            end
            rqa_pkg::ACT_DEBIT,
            rqa_pkg::ACT_CREDIT:
            begin
                priority if (!type_ok)
                begin
                    status_next = rqa_pkg::ST_BAD_TYPE;
                end
                else if (amount_reg[AW-1])
                begin
                    status_next = rqa_pkg::ST_NEG_AMOUNT;
                end
                else if (bypass_reg)
                begin
                    granted_next = 1'b1;
                end
                else if (action_reg == rqa_pkg::ACT_DEBIT)
                begin
                    if (debit_sum > {1'b0, lim_sel})
                    begin
                        status_next = rqa_pkg::ST_LIMIT;
                    end
                    else
                    begin
                        granted_next = 1'b1;
                        usage_we     = 1'b1;
                        usage_next   = debit_sum[CW-1:0];
                        if (refcount_reg != rqa_pkg::CNT_MAX)
                        begin
                            refcount_next = refcount_reg + CW'(1);
                        end
                    end
                end
                else
                begin
                    priority if (amount_reg[CW-1:0] > use_sel)
                    begin
                        status_next = rqa_pkg::ST_UNDERFLOW;
                    end
                    else if (rc_neg)
                    begin
                        status_next = rqa_pkg::ST_REF_NEGATIVE;
                    end
                    else if (rc_zero && (others_nz || (credit_diff != '0)))
                    begin
                        status_next = rqa_pkg::ST_RELEASE_BUSY;
                    end
                    else
                    begin
                        granted_next  = 1'b1;
                        usage_we      = 1'b1;
                        usage_next    = credit_diff;
                        refcount_next = rc_sat;
                        released_next = rc_zero;
                    end
                end
            end
            default:
            begin
                status_next = rqa_pkg::ST_BAD_TYPE;
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            action_reg <= action;
            type_reg   <= resource_type;
            amount_reg <= amount;
            delta_reg  <= refcount_delta;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            granted_reg      <= granted_next;
            status_reg       <= status_next;
            refcount_now_reg <= refcount_next;
            released_reg     <= released_next;
        end
    end

    // accounting state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                usage_reg[i] <= '0;
            end
            refcount_reg <= CW'(1);
        end
        else if (fire)
        begin
            refcount_reg <= refcount_next;
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                if (usage_we && (type_reg == 2'(i)))
                begin
                    usage_reg[i] <= usage_next;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rqa_pkg::MAX_TYPES; i++)
            begin
                limit_reg[i] <= '0;
            end
            bypass_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rqa_pkg::REG_LIMIT_ZERO: limit_reg[0] <= cfg_data;
                rqa_pkg::REG_LIMIT_ONE:  limit_reg[1] <= cfg_data;
                rqa_pkg::REG_LIMIT_TWO:  limit_reg[2] <= cfg_data;
                rqa_pkg::REG_BYPASS:     bypass_reg   <= cfg_data[0];
                default:                 bypass_reg   <= bypass_reg;
            endcase
        end
    end

    // a granted result always reports ok
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && granted_reg |-> status_reg == rqa_pkg::ST_OK)
        else $error("granted result with error status");

    // release means a granted item that left the count at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && released_reg |-> granted_reg && refcount_now_reg == '0)
        else $error("release without zero count");

    // a refused request leaves the reference count alone
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !granted_next |=> $stable(refcount_reg))
        else $error("refused request changed reference count");

    // bypass mode tracks nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && bypass_reg |=> $stable(refcount_reg) && !$past(usage_we))
        else $error("state changed in bypass mode");

    // reported count matches the state it leaves behind
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> refcount_now_reg == refcount_reg)
        else $error("reported count differs from state");

endmodule
